>>> sv/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the controller, the datapath and the top level.

package lrukv_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned VALUE_IN_W  = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the accepted request beat
    logic lookup;    // compare the request key against all entries
    logic update;    // apply hit/insert/evict, load the result register
  } lrukv_cmd_t;

endpackage

>>> sv/lrukv_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Depends on lrukv_pkg; drives the lrukv_cmd_t commands of the datapath.

module lrukv_ctrl import lrukv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lrukv_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  // The result register can take a new beat if it is empty or drains now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_UPDATE) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load_req = accept;
  assign cmd_o.lookup   = (state_q == ST_LOOKUP);
  assign cmd_o.update   = (state_q == ST_UPDATE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A lookup is always followed by the update step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_UPDATE))
    else $error("lookup not followed by update");

  // An update always presents a result beat on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_q)
    else $error("update lost its result beat");

  // A held result beat is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.update)
    else $error("result overwritten while stalled");

endmodule

>>> sv/lrukv_datapath.sv
// Datapath of the LRU key-value cache: entry stores, recency ranks, occupancy,
// capacity register and result register. Depends on lrukv_pkg.

module lrukv_datapath import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrukv_cmd_t            cmd_i,
  input  logic                  cfg_wr_en_i,
  input  logic [CFG_W-1:0]      cfg_wr_data_i,
  input  logic                  req_type_i,
  input  logic [KEY_IN_W-1:0]   key_i,
  input  logic [VALUE_IN_W-1:0] write_value_i,
  output logic                  hit_o,
  output logic [VALUE_IN_W-1:0] read_value_o
);

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  logic                   req_type_q;
  logic [KEY_WIDTH-1:0]   req_key_q;
  logic [VALUE_WIDTH-1:0] req_value_q;

  logic [KEY_WIDTH-1:0]   key_q   [ENTRIES];
  logic [VALUE_WIDTH-1:0] value_q [ENTRIES];
  logic [RANK_W-1:0]      rank_q  [ENTRIES];

  logic [OCC_W-1:0]       occ_q;
  logic [CFG_W-1:0]       cap_q;
  logic [ENTRIES-1:0]     match_q, match_d;
  logic                   out_hit_q;
  logic [VALUE_IN_W-1:0]  out_value_q;

  logic [ENTRIES-1:0]     valid;
  logic [ENTRIES-1:0]     target;
  logic [ENTRIES-1:0]     age;
  logic                   hit;
  logic [RANK_W-1:0]      hit_rank;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [CMP_W-1:0]       cap_ext, cap_eff;
  logic                   full, is_put, insert, evict, change;
  logic [OCC_W-1:0]       occ_last, threshold;

  // Entries are filled from slot 0 upward and an eviction refills its own
  // slot, so the valid slots are always the lowest occ_q ones.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i]   = OCC_W'(i) < occ_q;
      match_d[i] = valid[i] && (key_q[i] == req_key_q);
    end
  end

  // Keys are unique among valid entries, so match_q is one-hot or zero.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | ({RANK_W{match_q[i]}} & rank_q[i]);
      hit_value = hit_value | ({VALUE_WIDTH{match_q[i]}} & value_q[i]);
    end
  end

  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign hit      = |match_q;
  assign full     = CMP_W'(occ_q) >= cap_eff;
  assign is_put   = (req_type_q == REQ_PUT);
  assign insert   = is_put && !hit;
  assign evict    = insert && full;
  assign change   = hit || is_put;
  assign occ_last = occ_q - OCC_W'(1);

  // Every case is a promotion of one target slot: entries more recent than
  // the threshold age by one, the target becomes rank 0.
  always_comb begin
    if (hit) begin
      threshold = OCC_W'(hit_rank);
    end else if (evict) begin
      threshold = occ_last;
    end else begin
      threshold = occ_q;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit) begin
        target[i] = match_q[i];
      end else if (evict) begin
        target[i] = valid[i] && (OCC_W'(rank_q[i]) == occ_last);
      end else begin
        target[i] = (OCC_W'(i) == occ_q);
      end
      age[i] = valid[i] && !target[i] && (OCC_W'(rank_q[i]) < threshold);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q  <= req_type_i;
      req_key_q   <= KEY_WIDTH'(key_i);
      req_value_q <= VALUE_WIDTH'(write_value_i);
    end
    if (cmd_i.lookup) begin
      match_q <= match_d;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (change && target[i]) begin
          rank_q[i] <= '0;
          if (is_put) value_q[i] <= req_value_q;
          if (insert) key_q[i]   <= req_key_q;
        end else if (change && age[i]) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
      out_hit_q   <= hit;
      out_value_q <= (hit && !is_put) ? VALUE_IN_W'(hit_value) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      if (cfg_wr_en_i) cap_q <= cfg_wr_data_i;
      if (cmd_i.update && insert && !evict) occ_q <= occ_q + 1'b1;
    end
  end

  assign hit_o        = out_hit_q;
  assign read_value_o = out_value_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(match_q))
    else $error("duplicate key among valid entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && evict) |-> $onehot(target))
    else $error("no unique least recent entry to evict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

endmodule

>>> sv/lru_key_value_cache.sv
// Top level of the LRU key-value cache: stream ports and configuration port.
// Depends on lrukv_pkg, lrukv_ctrl and lrukv_datapath.
//
// Usage:
//   Requests arrive as beats on the s_axis channel: tuser[0] is the request
//   kind (0 get, 1 put), tdata carries key in [31:0] and write_value in
//   [63:32]. Each request yields exactly one result beat on m_axis:
//   tuser[0] is hit, tdata[31:0] the stored value on a get hit, else zero.
//   cfg_wr_en_i/cfg_wr_data_i write the capacity in use (0 acts as 1,
//   values above ENTRIES act as ENTRIES); write it only while idle.
// Sequencing:
//   An accepted request is captured, then compared against all entries in
//   the lookup step, then applied in the update step, which loads the
//   result register. The next request is taken on the same edge that
//   applies the previous one, so a new request is never taken before the
//   previous one is compared; the compare step and rank update step set the pace.
// Reset:
//   rst_ni clears the occupancy (all entries invalid), the result valid
//   flag and sets the capacity to 16. No clearing pass is needed.
// Stalls:
//   The result register holds its beat while m_axis_tready is low; the next
//   compared request then waits unapplied in the update step and s_axis_tready drops.

module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // [31:0] key, [63:32] write_value
  input  logic [0:0]            s_axis_tuser,   // [0] req_type
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [31:0] read_value
  output logic [0:0]            m_axis_tuser,   // [0] hit
  // capacity register
  input  logic                  cfg_wr_en_i,
  input  logic [CFG_W-1:0]      cfg_wr_data_i
);

  lrukv_cmd_t cmd;

  // Sequence each request: capture, compare, apply.
  lrukv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Hold the entries, ranks and the result beat.
  lrukv_datapath #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .req_type_i    (s_axis_tuser[0]),
    .key_i         (s_axis_tdata[KEY_IN_W-1:0]),
    .write_value_i (s_axis_tdata[KEY_IN_W+VALUE_IN_W-1:KEY_IN_W]),
    .hit_o         (m_axis_tuser[0]),
    .read_value_o  (m_axis_tdata)
  );

endmodule
